// ----- rtl/core/pes_pkg.sv -----
// Shared types, constants and reset values for the periodic event scheduler.
package pes_pkg;

  // Event table geometry
  localparam int NumEvents  = 5;   // events that a poll scans
  localparam int EventSlots = 5;   // event entries kept in storage
  localparam int IdxW       = 3;   // width of the event_index field
  localparam int TickW      = 32;
  localparam int CmdW       = 2;
  localparam int MaskW      = 5;

  // Config port geometry
  localparam int DataW = 32;
  localparam int AddrW = 5;

  typedef logic [TickW-1:0] tick_t;

  typedef enum logic [CmdW-1:0] {
    CMD_POLL     = 2'd0,
    CMD_ACTIVATE = 2'd1,
    CMD_ENABLE   = 2'd2,
    CMD_DISABLE  = 2'd3
  } cmd_e;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_PERIOD0 = 3'd0,
    REG_PERIOD1 = 3'd1,
    REG_PERIOD2 = 3'd2,
    REG_PERIOD3 = 3'd3,
    REG_PERIOD4 = 3'd4,
    REG_ONESHOT = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Configuration seen by the scheduler core
  typedef struct packed {
    tick_t [EventSlots-1:0] period;
    logic  [MaskW-1:0]      oneshot;
  } pes_cfg_t;

  // Reset values, entry zero on the right
  localparam tick_t [EventSlots-1:0] PeriodReset =
    {32'd180000, 32'd10, 32'd1000, 32'd20000, 32'd1000};
  localparam logic [MaskW-1:0] OneshotReset = 5'b01000;
  localparam logic [EventSlots-1:0] EnableReset = 5'b10011;
  localparam tick_t [EventSlots-1:0] StampReset =
    {32'd0, 32'd0, 32'd0, 32'd1, 32'd0};

endpackage

// ----- rtl/core/pes_intf.sv -----
// Valid/ready channel interfaces for scheduler requests and responses.
interface pes_req_if;
  import pes_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic [IdxW-1:0]     event_index;
  logic [TickW-1:0]    now;

  modport source (output valid, cmd, event_index, now, input ready);
  modport sink   (input valid, cmd, event_index, now, output ready);
endinterface

interface pes_rsp_if;
  import pes_pkg::*;

  logic                valid;
  logic                ready;
  logic [MaskW-1:0]    fire_mask;
  logic                accepted;

  modport source (output valid, fire_mask, accepted, input ready);
  modport sink   (input valid, fire_mask, accepted, output ready);
endinterface

// ----- rtl/core/pes_apb_regs.sv -----
// APB register file: event periods and one-shot mask.
module pes_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pes_pkg::AddrW-1:0]  paddr,
  input  logic [pes_pkg::DataW-1:0]  pwdata,
  output logic [pes_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pes_pkg::pes_cfg_t          cfg_o
);
  import pes_pkg::*;

  tick_t [EventSlots-1:0] period_q;
  logic  [MaskW-1:0]      oneshot_q;
  logic  [2:0]            reg_idx;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; addresses past the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PeriodReset;
      oneshot_q <= OneshotReset;
    end else if (wr_en) begin
      if (reg_idx < REG_ONESHOT) begin
        period_q[reg_idx] <= pwdata[TickW-1:0];
      end else if (reg_idx == REG_ONESHOT) begin
        oneshot_q <= pwdata[MaskW-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (reg_idx < REG_ONESHOT) begin
      prdata = period_q[reg_idx];
    end else if (reg_idx == REG_ONESHOT) begin
      prdata = {{(DataW-MaskW){1'b0}}, oneshot_q};
    end
  end

  assign cfg_o.period  = period_q;
  assign cfg_o.oneshot = oneshot_q;

endmodule

// ----- rtl/core/periodic_event_scheduler.sv -----
// Periodic event scheduler: one shared due-check unit walks the events per poll.
// Poll steps: accept the request, scan the events one per cycle through the
//   shared subtract/compare unit, then load the result register.
// Commands skip the scan. Not ready while an item is in flight.
// Result register lets the next item enter while a response waits to be taken.
// Async active-low reset restores periods, mask, enable flags and stamps.
module periodic_event_scheduler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pes_req_if.sink                    req_i,
  pes_rsp_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pes_pkg::AddrW-1:0]  paddr,
  input  logic [pes_pkg::DataW-1:0]  pwdata,
  output logic [pes_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import pes_pkg::*;

  pes_cfg_t cfg;

  state_e state_q, state_d;
  logic [IdxW-1:0]        cnt_q;
  tick_t                  now_q;
  logic [MaskW-1:0]       fired_q;
  logic                   acc_q;
  logic [EventSlots-1:0]  en_q;
  tick_t [EventSlots-1:0] stamp_q;

  logic                   out_valid_q;
  logic [MaskW-1:0]       out_fire_q;
  logic                   out_acc_q;

  logic   in_fire, out_free, load_out, idx_ok, is_poll, last_evt;
  cmd_e   cmd;
  tick_t  stamp_sel, period_sel, diff;
  logic   due;

  pes_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign cmd      = cmd_e'(req_i.cmd);
  assign is_poll  = (cmd == CMD_POLL);
  assign idx_ok   = (req_i.event_index < IdxW'(NumEvents));
  assign in_fire  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign last_evt = (cnt_q == IdxW'(NumEvents - 1));

  // Shared due-check unit: wrapping age against period
  assign stamp_sel  = stamp_q[cnt_q];
  assign period_sel = cfg.period[cnt_q];
  assign diff       = now_q - stamp_sel;
  assign due        = en_q[cnt_q] && ((stamp_sel == '0) || (diff >= period_sel));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = is_poll ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (last_evt) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_SCAN: ;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // Control and event state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      en_q        <= EnableReset;
      stamp_q     <= StampReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q <= '0;
        if (!is_poll && idx_ok) begin
          unique case (cmd)
            CMD_ACTIVATE: begin
              en_q[req_i.event_index]    <= 1'b1;
              stamp_q[req_i.event_index] <= '0;
            end
            CMD_ENABLE: begin
              en_q[req_i.event_index]    <= 1'b1;
              stamp_q[req_i.event_index] <= req_i.now;
            end
            CMD_DISABLE: en_q[req_i.event_index] <= 1'b0;
            default: ;
          endcase
        end
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
        if (due) begin
          stamp_q[cnt_q] <= now_q;
          if (cfg.oneshot[cnt_q]) en_q[cnt_q] <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q   <= req_i.now;
      fired_q <= '0;
      acc_q   <= is_poll || idx_ok;
    end else if (state_q == ST_SCAN && due) begin
      fired_q[cnt_q] <= 1'b1;
    end
    if (load_out) begin
      out_fire_q <= fired_q;
      out_acc_q  <= acc_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.fire_mask = out_fire_q;
  assign rsp_o.accepted  = out_acc_q;

`ifndef NO_ASSERTIONS
  // Scan counter never walks past the last event
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q < IdxW'(NumEvents)))
    else $error("scan counter out of range");

  // A command skips the scan and goes straight to the result
  a_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_poll) |=> (state_q == ST_DONE))
    else $error("command did not go to result state");

  // A rejected command never reports fired events
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !acc_q) |-> (fired_q == '0))
    else $error("rejected command with fire bits");

  // A poll always completes its scan in the cycle after the last event
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last_evt) |=> (state_q == ST_DONE))
    else $error("scan did not end after last event");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the periodic event scheduler: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import pes_pkg::*;

  // Directed table row: either a request beat or a register write
  typedef enum logic {ROW_ITEM, ROW_CFG} row_e;

  typedef struct {
    row_e            kind;
    cmd_e            cmd;
    logic [IdxW-1:0] idx;
    tick_t           now;
    reg_e            reg_sel;
    logic [31:0]     value;
    bit              typed;    // expectation written in the row
    logic [MaskW-1:0] mask;
    logic            acc;
  } dir_row_t;

  typedef struct packed {
    logic [MaskW-1:0] fire_mask;
    logic             accepted;
  } sched_rsp_t;

  localparam int DirRows     = 37;
  localparam int RandPhases  = 6;
  localparam int PhaseItems  = 240;
  localparam int MaxReported = 10;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  pes_req_if req_bus ();
  pes_rsp_if rsp_bus ();

  periodic_event_scheduler u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the event table and configuration
  tick_t            ev_period  [EventSlots];
  logic             ev_enabled [EventSlots];
  tick_t            ev_stamp   [EventSlots];
  logic [MaskW-1:0] oneshot_bits;

  sched_rsp_t pending_rsp_q [$];
  sched_rsp_t head_rsp;

  bit quiet;
  int n_errors;
  int n_items;
  int n_polls;
  int n_fires;
  int n_rejects;
  int n_checked;
  int n_cfg;

  // Directed stimulus; typed rows carry their expectation
  dir_row_t dir_tab [DirRows] = '{
    // reset configuration
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd5,          REG_PERIOD0, 32'd0, 1'b1, 5'd17, 1'b1},
    '{ROW_ITEM, CMD_ACTIVATE, 3'd7, 32'd0,          REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_ENABLE,   3'd5, 32'd9,          REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_DISABLE,  3'd6, 32'd9,          REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_ACTIVATE, 3'd3, 32'd9,          REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd0,          REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1,          REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1,          REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_ENABLE,   3'd2, 32'd100,        REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1099,       REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1100,       REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_DISABLE,  3'd0, 32'd1100,       REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'hFFFF_FFFF,  REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd7, 32'hFFFF_FFFF,  REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    // zero periods, no one-shot events
    '{ROW_CFG,  CMD_POLL,     3'd0, 32'd0,          REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_CFG,  CMD_POLL,     3'd0, 32'd0,          REG_PERIOD1, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_CFG,  CMD_POLL,     3'd0, 32'd0,          REG_PERIOD2, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_CFG,  CMD_POLL,     3'd0, 32'd0,          REG_PERIOD3, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_CFG,  CMD_POLL,     3'd0, 32'd0,          REG_PERIOD4, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_CFG,  CMD_POLL,     3'd0, 32'd0,          REG_ONESHOT, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_ENABLE,   3'd0, 32'd1234,       REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_ACTIVATE, 3'd3, 32'd1234,       REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1234,       REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd5, 32'd1234,       REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    // maximum periods, every event one-shot
    '{ROW_CFG,  CMD_POLL, 3'd0, 32'd0, REG_PERIOD0, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
    '{ROW_CFG,  CMD_POLL, 3'd0, 32'd0, REG_PERIOD1, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
    '{ROW_CFG,  CMD_POLL, 3'd0, 32'd0, REG_PERIOD2, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
    '{ROW_CFG,  CMD_POLL, 3'd0, 32'd0, REG_PERIOD3, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
    '{ROW_CFG,  CMD_POLL, 3'd0, 32'd0, REG_PERIOD4, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
    '{ROW_CFG,  CMD_POLL, 3'd0, 32'd0, REG_ONESHOT, 32'd31,        1'b0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1235,       REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_ACTIVATE, 3'd1, 32'd1235,       REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'h8000_0000,  REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'h7FFF_FFFF,  REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_ACTIVATE, 3'd4, 32'd0,          REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1},
    '{ROW_ITEM, CMD_POLL,     3'd0, 32'd1233,       REG_PERIOD0, 32'd0, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM, CMD_DISABLE,  3'd4, 32'd1233,       REG_PERIOD0, 32'd0, 1'b1, 5'd0,  1'b1}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_error(string msg);
    n_errors++;
    if (n_errors <= MaxReported) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Scan or command against the shadow table; returns the response beat
  function automatic sched_rsp_t evaluate_request(cmd_e cmd, logic [IdxW-1:0] idx, tick_t now);
    sched_rsp_t rsp;
    tick_t      elapsed;
    rsp.fire_mask = '0;
    rsp.accepted  = 1'b1;
    if (cmd == CMD_POLL) begin
      for (int i = 0; i < NumEvents; i++) begin
        if (ev_enabled[i]) begin
          elapsed = now - ev_stamp[i];
          // a zero stamp always means due
          if (ev_stamp[i] == '0 || elapsed >= ev_period[i]) begin
            ev_stamp[i]      = now;
            rsp.fire_mask[i] = 1'b1;
            if (oneshot_bits[i]) ev_enabled[i] = 1'b0;
          end
        end
      end
    end else if (idx >= NumEvents) begin
      rsp.accepted = 1'b0;
    end else begin
      case (cmd)
        CMD_ACTIVATE: begin
          ev_enabled[idx] = 1'b1;
          ev_stamp[idx]   = '0;
        end
        CMD_ENABLE: begin
          ev_enabled[idx] = 1'b1;
          ev_stamp[idx]   = now;
        end
        default: ev_enabled[idx] = 1'b0;
      endcase
    end
    return rsp;
  endfunction

  // One request beat, with an optional random gap ahead of it
  task automatic send_item(cmd_e cmd, logic [IdxW-1:0] idx, tick_t now, bit typed,
                           sched_rsp_t typed_rsp);
    sched_rsp_t predicted;
    int         gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk_i);
        req_bus.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= cmd;
    req_bus.event_index <= idx;
    req_bus.now         <= now;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    predicted = evaluate_request(cmd, idx, now);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    n_items++;
    if (cmd == CMD_POLL) n_polls++;
    if (!predicted.accepted) n_rejects++;
    n_fires += $countones(predicted.fire_mask);
  endtask

  // Drop valid and let every outstanding response arrive
  task automatic wait_idle();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(reg_e sel, logic [31:0] value);
    logic [31:0] stored;
    stored = (sel == REG_ONESHOT) ? {27'd0, value[MaskW-1:0]} : value;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (sel == REG_ONESHOT) oneshot_bits = value[MaskW-1:0];
    else ev_period[int'(sel)] = value;
    n_cfg++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== stored)
      flag_error($sformatf("%s read back: expected %h, got %h", sel.name(), stored, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        flag_error($sformatf("unexpected response fire_mask=%b accepted=%b",
                             rsp_bus.fire_mask, rsp_bus.accepted));
      end else begin
        head_rsp = pending_rsp_q.pop_front();
        n_checked++;
        if (rsp_bus.fire_mask !== head_rsp.fire_mask)
          flag_error($sformatf("fire_mask: expected %b, got %b",
                               head_rsp.fire_mask, rsp_bus.fire_mask));
        if (rsp_bus.accepted !== head_rsp.accepted)
          flag_error($sformatf("accepted: expected %b, got %b",
                               head_rsp.accepted, rsp_bus.accepted));
      end
    end
  end

  // Response ready: open stretches broken by stall bursts
  initial begin
    int stall_left;
    int open_left;
    stall_left = 0;
    open_left  = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (open_left != 0) begin
          open_left--;
        end else if (!quiet) begin
          stall_left = $urandom_range(1, 11);
          open_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                   : $urandom_range(0, 8);
        end
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main stimulus
  initial begin
    tick_t           tick;
    logic [31:0]     cfg_val;
    int              roll;
    cmd_e            cmd;
    logic [IdxW-1:0] idx;

    rst_ni              <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.cmd         <= CMD_POLL;
    req_bus.event_index <= '0;
    req_bus.now         <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    quiet = 1'b0;
    for (int i = 0; i < EventSlots; i++) begin
      ev_period[i]  = PeriodReset[i];
      ev_enabled[i] = EnableReset[i];
      ev_stamp[i]   = StampReset[i];
    end
    oneshot_bits = OneshotReset;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[i].reg_sel, dir_tab[i].value);
      end else begin
        send_item(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].now, dir_tab[i].typed,
                  {dir_tab[i].mask, dir_tab[i].acc});
      end
    end

    // Random phases, each with a fresh register setting; the last one runs flat out
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      quiet = (ph == RandPhases - 1);
      for (int r = 0; r <= int'(REG_ONESHOT); r++) begin
        roll = $urandom_range(0, 99);
        if (r == int'(REG_ONESHOT)) cfg_val = $urandom_range(0, 31);
        else if (roll < 10)         cfg_val = '0;
        else if (roll < 15)         cfg_val = 32'hFFFF_FFFF;
        else if (roll < 22)         cfg_val = $urandom;
        else                        cfg_val = $urandom_range(1, 300);
        write_reg(reg_e'(r), cfg_val);
      end
      tick = (ph == 1) ? 32'hFFFF_FF00 : $urandom;
      for (int k = 0; k < PhaseItems; k++) begin
        // mostly a slowly advancing tick, with jumps and wraps
        roll = $urandom_range(0, 99);
        if (roll < 85)      tick = tick + $urandom_range(0, 40);
        else if (roll < 93) tick = tick + $urandom_range(0, 4000);
        else if (roll < 97) tick = $urandom;
        else if (roll < 99) tick = 32'hFFFF_FFFF - $urandom_range(0, 30);
        else                tick = '0;
        roll = $urandom_range(0, 99);
        if (roll < 55)      cmd = CMD_POLL;
        else if (roll < 70) cmd = CMD_ACTIVATE;
        else if (roll < 85) cmd = CMD_ENABLE;
        else                cmd = CMD_DISABLE;
        idx = ($urandom_range(0, 4) == 0) ? IdxW'($urandom_range(0, 7))
                                          : IdxW'($urandom_range(0, 4));
        send_item(cmd, idx, tick, 1'b0, '0);
      end
    end

    // Drain and settle
    wait_idle();
    repeat (12) @(posedge clk_i);
    if (pending_rsp_q.size() != 0)
      flag_error($sformatf("%0d responses never arrived", pending_rsp_q.size()));

    $display("Covered %0d requests (%0d polls, %0d rejected indexes) over %0d register writes",
             n_items, n_polls, n_rejects, n_cfg);
    $display("Checked %0d responses carrying %0d event fires; %0d mismatches",
             n_checked, n_fires, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
